// File: sv/lut_network_truth_evaluator_assert.svh
// Assertion macros used by the LUT network evaluator top level.
// No dependencies; included by the top level, the only module that carries assertions.
`ifndef LUT_NETWORK_TRUTH_EVALUATOR_ASSERT_SVH
`define LUT_NETWORK_TRUTH_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LNT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lnt_pkg.sv
// Package for the LUT network evaluator: types, constants, register indexes.
// No dependencies.
package lnt_pkg;

  localparam int TT_W       = 64;
  localparam int FUNC_W     = 63;
  localparam int IDX_W      = 6;
  localparam int FANINS_MAX = 6;
  localparam int SLOT_W     = 3;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int S_DATA_W   = 104;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUT_SIZE   = 2'd2;

  typedef logic [FANINS_MAX-1:0][TT_W-1:0] fan_set_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_WRITE
  } lnt_state_t;

  function automatic logic [TT_W-1:0] elem_pattern(input logic [SLOT_W-1:0] i);
    logic [TT_W-1:0] p;
    case (i)
      3'd0:    p = 64'hAAAAAAAAAAAAAAAA;
      3'd1:    p = 64'hCCCCCCCCCCCCCCCC;
      3'd2:    p = 64'hF0F0F0F0F0F0F0F0;
      3'd3:    p = 64'hFF00FF00FF00FF00;
      3'd4:    p = 64'hFFFF0000FFFF0000;
      3'd5:    p = 64'hFFFFFFFF00000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: sv/lnt_table_ram.sv
// Node table store: one write port, one read port with registered data.
// Depends on lnt_pkg.
module lnt_table_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [lnt_pkg::TT_W-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [lnt_pkg::TT_W-1:0] rdata
);
  import lnt_pkg::*;

  logic [TT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lnt_lut_eval.sv
// Bitwise evaluation of one LUT node over 64 truth-table lanes.
// Depends on lnt_pkg.
module lnt_lut_eval (
  input  lnt_pkg::fan_set_t                  fan,
  input  logic [lnt_pkg::FUNC_W-1:0]         func,
  input  logic [lnt_pkg::SLOT_W-1:0]         lut_k,
  output logic [lnt_pkg::TT_W-1:0]           truth
);
  import lnt_pkg::*;

  logic [FANINS_MAX-1:0] mask;
  logic [TT_W-1:0]       func_ext;

  // Each lane forms its minterm from the fanin bits; minterm 0 maps to the zero bit.
  assign mask     = FANINS_MAX'((7'd1 << lut_k) - 7'd1);
  assign func_ext = {func, 1'b0};

  always_comb begin
    logic [FANINS_MAX-1:0] t;
    for (int b = 0; b < TT_W; b++) begin
      for (int v = 0; v < FANINS_MAX; v++) begin
        t[v] = fan[v][b];
      end
      truth[b] = func_ext[t & mask];
    end
  end

endmodule

// File: sv/lut_network_truth_evaluator.sv
// Top level of the LUT network evaluator: sequencer, node store and lane logic.
// Depends on lnt_pkg, lnt_table_ram, lnt_lut_eval and the assertion header.
//
// Usage: each transfer on the s_ channel describes one node of a LUT network.
// The node's fanins are fetched one slot per cycle, primary inputs from the
// elementary patterns and earlier nodes from the node store, which has one
// read port with registered read data. The node's table is then formed over
// all 64 lanes and written back to the store.
// An item passes from its accept through one fetch step per fanin slot (set
// by the single read port), a step to catch the last read and write-back
// before the next s_tready; write-back can hold only for a network's last node.
// After num_nodes items (0 as 1, at most NODES_MAX) the last node's table
// leaves on m_tdata with the fanin error flag in m_tuser, in the cycle after
// write-back. The result waits in an output register; the next item is
// accepted while it waits, and only the next network's last node holds in
// write-back if the receiver still stalls. Reset loads the register defaults,
// clears the node count and error flag and needs no pass over the store.
`include "lut_network_truth_evaluator_assert.svh"
module lut_network_truth_evaluator #(
  parameter int NODES_MAX = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lnt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // fanin_0 [5:0], fanin_1 [11:6], fanin_2 [17:12], fanin_3 [23:18],
  // fanin_4 [29:24], fanin_5 [35:30], function_bits [98:36], zeros above.
  input  logic [lnt_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // output_truth [63:0].
  output logic [lnt_pkg::TT_W-1:0]      m_tdata,
  // fanin_error [0].
  output logic                          m_tuser
);
  import lnt_pkg::*;

  localparam int AW = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;

  logic [2:0]   num_inputs;
  logic [5:0]   num_nodes;
  logic [2:0]   lut_size;

  lnt_state_t   state;
  lnt_state_t   state_next;

  logic [FANINS_MAX-1:0][IDX_W-1:0] fanin_q;
  logic [FUNC_W-1:0]   func_q;
  fan_set_t            fan;
  logic [SLOT_W-1:0]   slot;
  logic                rd_pend;
  logic [SLOT_W-1:0]   rd_slot;
  logic [AW-1:0]       node_count;
  logic                error_seen;

  logic [2:0]          m_eff;
  logic [SLOT_W-1:0]   k_eff;
  logic [6:0]          n_raw;
  logic [6:0]          n_eff;
  logic                is_last;
  logic                out_free;
  logic [IDX_W-1:0]    cur_idx;
  logic [IDX_W-1:0]    node_idx;
  logic                in_use;
  logic                is_prim;
  logic                bad_ref;
  logic                accept;
  logic                emit;
  logic                advance;

  logic                tbl_re;
  logic                tbl_we;
  logic [TT_W-1:0]     tbl_rdata;
  logic [TT_W-1:0]     truth;

  assign m_eff   = (num_inputs > 3'd6) ? 3'd6 : num_inputs;
  assign k_eff   = (lut_size > SLOT_W'(FANINS_MAX)) ? SLOT_W'(FANINS_MAX) : lut_size;
  assign n_raw   = (num_nodes == 6'd0) ? 7'd1 : {1'b0, num_nodes};
  assign n_eff   = (n_raw > 7'(NODES_MAX)) ? 7'(NODES_MAX) : n_raw;
  assign is_last = (7'(node_count) + 7'd1) >= n_eff;
  assign out_free = !m_tvalid || m_tready;

  assign cur_idx  = fanin_q[slot];
  assign in_use   = slot < k_eff;
  assign is_prim  = cur_idx < {3'b000, m_eff};
  assign node_idx = cur_idx - {3'b000, m_eff};
  assign bad_ref  = !is_prim && (node_idx >= IDX_W'(node_count));

  assign accept  = s_tvalid && s_tready;
  assign advance = !is_last || out_free;
  assign emit    = (state == ST_WRITE) && is_last && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (slot == SLOT_W'(FANINS_MAX - 1)) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    tbl_re   = 1'b0;
    tbl_we   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_FETCH: begin
        tbl_re = in_use && !is_prim && !bad_ref;
      end
      ST_EVAL: begin
      end
      ST_WRITE: begin
        tbl_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inputs <= 3'd6;
      num_nodes  <= 6'd1;
      lut_size   <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_INPUTS: num_inputs <= cfg_data[2:0];
        REG_NUM_NODES:  num_nodes  <= cfg_data;
        REG_LUT_SIZE:   lut_size   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int v = 0; v < FANINS_MAX; v++) begin
        fanin_q[v] <= s_tdata[v*IDX_W +: IDX_W];
      end
      func_q <= s_tdata[FANINS_MAX*IDX_W +: FUNC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= tbl_re;
      if (accept) begin
        slot <= '0;
      end else if (state == ST_FETCH) begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      rd_slot <= slot;
    end
    if (state == ST_FETCH) begin
      if (!in_use || bad_ref) begin
        fan[slot] <= '0;
      end else if (is_prim) begin
        fan[slot] <= elem_pattern(cur_idx[SLOT_W-1:0]);
      end
    end
    if (rd_pend) begin
      fan[rd_slot] <= tbl_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      error_seen <= 1'b0;
    end else if (emit) begin
      node_count <= '0;
      error_seen <= 1'b0;
    end else begin
      if ((state == ST_FETCH) && in_use && bad_ref) begin
        error_seen <= 1'b1;
      end
      if ((state == ST_WRITE) && !is_last) begin
        node_count <= node_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= truth;
      m_tuser <= error_seen;
    end
  end

  lnt_table_ram #(
    .DEPTH (NODES_MAX),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (node_count),
    .wdata (truth),
    .re    (tbl_re),
    .raddr (node_idx[AW-1:0]),
    .rdata (tbl_rdata)
  );

  lnt_lut_eval u_eval (
    .fan   (fan),
    .func  (func_q),
    .lut_k (k_eff),
    .truth (truth)
  );

  `LNT_ASSERT_NEXT(a_accept_fetch, accept, state == ST_FETCH, "accepted item did not start fetch")
  `LNT_ASSERT_IMPL(a_read_window, rd_pend, state == ST_FETCH || state == ST_EVAL, "read data outside fetch")
  `LNT_ASSERT_NEXT(a_emit_clears, emit, node_count == '0 && !error_seen, "network not cleared")
  `LNT_ASSERT_IMPL(a_result_source, $rose(m_tvalid), $past(state) == ST_WRITE, "result without write-back")

endmodule
